// ----- sv/rcle_pkg.sv -----
// shared types, codes and mod-26 letter helpers for the rotor cipher letter engine
// no dependencies; imported by the top level
package rcle_pkg;

  localparam int LETTERS = 26;

  // stepping checks by multiply with modular inverse, no divider
  // x % 39 == 0   <=> (x * 28567) mod 2^16 <= 1680
  // x % 1014 == 0 <=> x even and ((x >> 1) * 24883) mod 2^15 <= 64
  localparam logic [15:0] MID_INV   = 16'd28567;
  localparam logic [15:0] MID_LIMIT = 16'd1680;
  localparam logic [14:0] LEFT_INV   = 15'd24883;
  localparam logic [14:0] LEFT_LIMIT = 15'd64;

  typedef enum logic [2:0] {
    OP_ENCRYPT   = 3'd0,
    OP_STEP      = 3'd1,
    OP_LOAD_FWD  = 3'd2,
    OP_LOAD_BWD  = 3'd3,
    OP_LOAD_REFL = 3'd4,
    OP_LOAD_CORE = 3'd5,
    OP_SET_POS   = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    CFG_DRUM_SLOT1 = 3'd0,
    CFG_DRUM_SLOT2 = 3'd1,
    CFG_DRUM_SLOT3 = 3'd2,
    CFG_RING_SLOT1 = 3'd3,
    CFG_RING_SLOT2 = 3'd4,
    CFG_RING_SLOT3 = 3'd5,
    CFG_REFLECTOR  = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_FWD3,
    SEQ_FWD2,
    SEQ_FWD1,
    SEQ_REFL,
    SEQ_BWD1,
    SEQ_BWD2,
    SEQ_BWD3
  } seq_state_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [4:0]  letter;
    logic [15:0] iteration;
    logic [2:0]  table_select;
    logic [1:0]  slot;
    logic [4:0]  entry_index;
    logic [4:0]  entry_value;
  } item_t;

  function automatic logic [4:0] red26(input logic [4:0] a);
    logic [4:0] r;
    r = a;
    if (a >= 5'(LETTERS)) r = a - 5'(LETTERS);
    return r;
  endfunction

  function automatic logic [4:0] add26(input logic [4:0] a, input logic [4:0] b);
    logic [5:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 6'(LETTERS)) s = s - 6'(LETTERS);
    return s[4:0];
  endfunction

  function automatic logic [4:0] sub26(input logic [4:0] a, input logic [4:0] b);
    logic [5:0] s;
    if (a >= b) s = {1'b0, a} - {1'b0, b};
    else s = {1'b0, a} + 6'(LETTERS) - {1'b0, b};
    return s[4:0];
  endfunction

  function automatic logic [4:0] adv26(input logic [4:0] a);
    logic [4:0] r;
    if (a == 5'(LETTERS - 1)) r = 5'd0;
    else r = a + 5'd1;
    return r;
  endfunction

endpackage

// ----- sv/rcle_ram.sv -----
// generic single-write, single-read synchronous ram with registered read data
// no dependencies; used for the wiring tables and the core offsets
module rcle_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 26,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/rotor_cipher_letter_engine.sv -----
// rotor cipher letter engine: three-drum substitution with reflector, tables held in ram
// depends on rcle_pkg and rcle_ram
//
// Usage
//   s_axis carries one item per transfer: the operation in tuser, its operands in tdata.
//   Loads fill the forward, backward and reflector wirings and the core offsets; step
//   and set-position items move the drums; encrypt items run a letter through them.
//   m_axis returns exactly one result per item: the cipher letter (zero for all but
//   encrypt) and the three drum positions after the item.
//   cfg is a write-only register port, always ready; write it only while no item is
//   in flight.
// Sequencing
//   An item enters a holding register, then runs. An encrypt item steps the sequencer
//   through FWD3, FWD2, FWD1, REFL, BWD1, BWD2 and BWD3, the chain of seven dependent
//   lookups in the single-read-port wiring ram plus the core offset read before them,
//   and no item issues until it is done. Other items update positions and result once
//   the result register is free, after any earlier encrypt's result is registered.
// Reset and stall
//   rst clears positions, rings, reflector choice and all handshake state, sets drum
//   types to 0, 1, 2; ram contents stay undefined until loaded. The result register holds
//   while m_axis_tready is low; one more item is then held and an encrypt may run.
module rotor_cipher_letter_engine #(
  parameter int NUM_DRUM_TYPES = 8,
  parameter int NUM_SLOTS = 3
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // letter[4:0], iteration[20:5], table_select[23:21], slot[25:24],
  // entry_index[30:26], entry_value[35:31], zero pad
  input  logic [39:0] s_axis_tdata,
  // operation[2:0]
  input  logic [2:0]  s_axis_tuser,
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // cipher_letter[4:0], position_slot1[9:5], position_slot2[14:10],
  // position_slot3[19:15], zero pad
  output logic [23:0] m_axis_tdata,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [4:0]  cfg_data
);
  import rcle_pkg::*;

  localparam int TW = $clog2(NUM_DRUM_TYPES);
  localparam int WDEPTH = (2 * NUM_DRUM_TYPES + 2) * LETTERS;
  localparam int AW = $clog2(WDEPTH);
  localparam logic [AW-1:0] FWD_BASE = '0;
  localparam logic [AW-1:0] BWD_BASE = AW'(NUM_DRUM_TYPES * LETTERS);
  localparam logic [AW-1:0] REFL_BASE = AW'(2 * NUM_DRUM_TYPES * LETTERS);

  function automatic logic [TW-1:0] type_of(input logic [2:0] v);
    int w;
    w = int'(v);
    if (w >= 2 * NUM_DRUM_TYPES) w = w - 2 * NUM_DRUM_TYPES;
    else if (w >= NUM_DRUM_TYPES) w = w - NUM_DRUM_TYPES;
    return TW'(w);
  endfunction

  function automatic logic [AW-1:0] wire_addr(input logic [AW-1:0] base,
                                               input logic [TW-1:0] t,
                                               input logic [4:0] c);
    return base + AW'(t) * AW'(LETTERS) + AW'(c);
  endfunction

  // config registers
  logic [2:0] drum_type [NUM_SLOTS];
  logic [4:0] ring [NUM_SLOTS];
  logic       refl_type;

  // drum state
  logic [4:0] pos [NUM_SLOTS];
  logic [4:0] pos_next [NUM_SLOTS];

  // holding register
  item_t itm;
  logic  itm_valid;
  logic  itm_go;
  logic  is_enc;

  // sequencer
  seq_state_t state, state_next;
  logic       fin;
  logic [4:0] letter_q;
  logic [4:0] sh [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] sh_ld;
  logic [4:0] sh_new;
  logic [4:0] cont;
  logic [4:0] xv;
  logic [4:0] pos_ring [NUM_SLOTS];
  logic [TW-1:0] slot_type [NUM_SLOTS];

  // result register
  logic       m_valid;
  logic       res_free;
  logic [4:0] res_cipher;
  logic [4:0] res_pos [NUM_SLOTS];

  // ram ports
  logic          wr_we;
  logic [AW-1:0] wr_waddr;
  logic [AW-1:0] wr_raddr;
  logic [AW-1:0] raddr_q;
  logic [4:0]    wr_rdata;
  logic          cr_we;
  logic [TW-1:0] cr_waddr;
  logic [TW-1:0] cr_raddr;
  logic [4:0]    cr_rdata;

  logic       sel_drum_ok;
  logic       sel_refl_ok;
  logic       idx_ok;
  logic [4:0] val26;
  logic [15:0] mid_chk;
  logic [14:0] left_chk;
  logic        mid_step;
  logic        left_step;

  assign cfg_ready = 1'b1;

  always_comb begin
    for (int s = 0; s < NUM_SLOTS; s++) begin
      slot_type[s] = type_of(drum_type[s]);
      pos_ring[s] = sub26(pos[s], red26(ring[s]));
    end
  end

  // handshake and issue
  assign is_enc = (itm.operation == OP_ENCRYPT);
  assign res_free = !m_valid || m_axis_tready;
  assign itm_go = itm_valid && (state == SEQ_IDLE) &&
                  (is_enc ? (!fin || res_free) : (!fin && res_free));
  assign s_axis_tready = !itm_valid || itm_go;
  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata = {4'd0, res_pos[2], res_pos[1], res_pos[0], res_cipher};

  // operand checks for loads
  assign sel_drum_ok = int'(itm.table_select) < NUM_DRUM_TYPES;
  assign sel_refl_ok = (itm.table_select[2:1] == 2'd0);
  assign idx_ok = itm.entry_index < 5'(LETTERS);
  assign val26 = red26(itm.entry_value);

  assign mid_chk = itm.iteration * MID_INV;
  assign left_chk = itm.iteration[15:1] * LEFT_INV;
  assign mid_step = (mid_chk <= MID_LIMIT);
  assign left_step = !itm.iteration[0] && (left_chk <= LEFT_LIMIT);

  // positions after a non-encrypt item
  always_comb begin
    for (int s = 0; s < NUM_SLOTS; s++) begin
      pos_next[s] = pos[s];
    end
    unique case (op_t'(itm.operation))
      OP_STEP: begin
        pos_next[0] = adv26(pos[0]);
        if (mid_step) pos_next[1] = adv26(pos[1]);
        if (left_step) pos_next[2] = adv26(pos[2]);
      end
      OP_SET_POS: begin
        if (int'(itm.slot) < NUM_SLOTS) pos_next[itm.slot] = val26;
      end
      default: begin
      end
    endcase
  end

  // table writes from load items
  always_comb begin
    wr_we = 1'b0;
    wr_waddr = '0;
    cr_we = 1'b0;
    cr_waddr = TW'(itm.table_select);
    if (itm_go) begin
      unique case (op_t'(itm.operation))
        OP_LOAD_FWD: begin
          wr_we = sel_drum_ok && idx_ok;
          wr_waddr = wire_addr(FWD_BASE, TW'(itm.table_select), itm.entry_index);
        end
        OP_LOAD_BWD: begin
          wr_we = sel_drum_ok && idx_ok;
          wr_waddr = wire_addr(BWD_BASE, TW'(itm.table_select), itm.entry_index);
        end
        OP_LOAD_REFL: begin
          wr_we = sel_refl_ok && idx_ok;
          wr_waddr = REFL_BASE + AW'(itm.table_select[0]) * AW'(LETTERS)
                     + AW'(itm.entry_index);
        end
        OP_LOAD_CORE: begin
          cr_we = sel_drum_ok;
        end
        default: begin
        end
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      SEQ_IDLE: if (itm_go && is_enc) state_next = SEQ_FWD3;
      SEQ_FWD3: state_next = SEQ_FWD2;
      SEQ_FWD2: state_next = SEQ_FWD1;
      SEQ_FWD1: state_next = SEQ_REFL;
      SEQ_REFL: state_next = SEQ_BWD1;
      SEQ_BWD1: state_next = SEQ_BWD2;
      SEQ_BWD2: state_next = SEQ_BWD3;
      SEQ_BWD3: state_next = SEQ_IDLE;
      default:  state_next = SEQ_IDLE;
    endcase
  end

  // sequencer outputs: each state consumes the previous lookup and issues the next
  always_comb begin
    sh_ld = '0;
    sh_new = 5'd0;
    xv = 5'd0;
    cont = 5'd0;
    wr_raddr = '0;
    cr_raddr = slot_type[2];
    unique case (state)
      SEQ_IDLE: begin
        // keep rereading the last backward lookup so a stalled result stays valid
        wr_raddr = raddr_q;
        cr_raddr = slot_type[2];
      end
      SEQ_FWD3: begin
        sh_new = sub26(pos_ring[2], cr_rdata);
        sh_ld[2] = 1'b1;
        cont = add26(letter_q, sh_new);
        wr_raddr = wire_addr(FWD_BASE, slot_type[2], cont);
        cr_raddr = slot_type[1];
      end
      SEQ_FWD2: begin
        sh_new = sub26(pos_ring[1], cr_rdata);
        sh_ld[1] = 1'b1;
        xv = sub26(wr_rdata, sh[2]);
        cont = add26(xv, sh_new);
        wr_raddr = wire_addr(FWD_BASE, slot_type[1], cont);
        cr_raddr = slot_type[0];
      end
      SEQ_FWD1: begin
        sh_new = sub26(pos_ring[0], cr_rdata);
        sh_ld[0] = 1'b1;
        xv = sub26(wr_rdata, sh[1]);
        cont = add26(xv, sh_new);
        wr_raddr = wire_addr(FWD_BASE, slot_type[0], cont);
      end
      SEQ_REFL: begin
        xv = sub26(wr_rdata, sh[0]);
        wr_raddr = REFL_BASE + AW'(refl_type) * AW'(LETTERS) + AW'(xv);
      end
      SEQ_BWD1: begin
        xv = wr_rdata;
        cont = add26(xv, sh[0]);
        wr_raddr = wire_addr(BWD_BASE, slot_type[0], cont);
      end
      SEQ_BWD2: begin
        xv = sub26(wr_rdata, sh[0]);
        cont = add26(xv, sh[1]);
        wr_raddr = wire_addr(BWD_BASE, slot_type[1], cont);
      end
      SEQ_BWD3: begin
        xv = sub26(wr_rdata, sh[1]);
        cont = add26(xv, sh[2]);
        wr_raddr = wire_addr(BWD_BASE, slot_type[2], cont);
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
      fin <= 1'b0;
      itm_valid <= 1'b0;
      m_valid <= 1'b0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        pos[s] <= 5'd0;
        ring[s] <= 5'd0;
        drum_type[s] <= 3'(s);
      end
      refl_type <= 1'b0;
    end else begin
      state <= state_next;

      if (s_axis_tvalid && s_axis_tready) itm_valid <= 1'b1;
      else if (itm_go) itm_valid <= 1'b0;

      // result of the finished encrypt leaves ahead of any later item
      if (state == SEQ_BWD3) fin <= 1'b1;
      else if (fin && res_free) fin <= 1'b0;

      if ((fin && res_free) || (itm_go && !is_enc)) m_valid <= 1'b1;
      else if (m_axis_tready) m_valid <= 1'b0;

      if (itm_go && !is_enc) begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
          pos[s] <= pos_next[s];
        end
      end

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_DRUM_SLOT1: drum_type[0] <= cfg_data[2:0];
          CFG_DRUM_SLOT2: drum_type[1] <= cfg_data[2:0];
          CFG_DRUM_SLOT3: drum_type[2] <= cfg_data[2:0];
          CFG_RING_SLOT1: ring[0] <= cfg_data;
          CFG_RING_SLOT2: ring[1] <= cfg_data;
          CFG_RING_SLOT3: ring[2] <= cfg_data;
          CFG_REFLECTOR:  refl_type <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_axis_tready) begin
      itm.operation <= s_axis_tuser;
      itm.letter <= s_axis_tdata[4:0];
      itm.iteration <= s_axis_tdata[20:5];
      itm.table_select <= s_axis_tdata[23:21];
      itm.slot <= s_axis_tdata[25:24];
      itm.entry_index <= s_axis_tdata[30:26];
      itm.entry_value <= s_axis_tdata[35:31];
    end
    raddr_q <= wr_raddr;
    if (itm_go && is_enc) letter_q <= red26(itm.letter);
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (sh_ld[s]) sh[s] <= sh_new;
    end
    if (fin && res_free) begin
      res_cipher <= sub26(wr_rdata, sh[2]);
      for (int s = 0; s < NUM_SLOTS; s++) begin
        res_pos[s] <= pos[s];
      end
    end else if (itm_go && !is_enc) begin
      res_cipher <= 5'd0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        res_pos[s] <= pos_next[s];
      end
    end
  end

  // forward, backward and reflector wirings share one ram
  rcle_ram #(
    .WIDTH(5),
    .DEPTH(WDEPTH)
  ) u_wiring (
    .clk   (clk),
    .we    (wr_we),
    .waddr (wr_waddr),
    .wdata (val26),
    .raddr (wr_raddr),
    .rdata (wr_rdata)
  );

  rcle_ram #(
    .WIDTH(5),
    .DEPTH(NUM_DRUM_TYPES)
  ) u_core (
    .clk   (clk),
    .we    (cr_we),
    .waddr (cr_waddr),
    .wdata (val26),
    .raddr (cr_raddr),
    .rdata (cr_rdata)
  );

endmodule
